// ===== rtl/bsc_pkg.sv =====
// Shared types, constants and helpers for the barometric compensation pipeline.
package bsc_pkg;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic        [63:0] p2_to_p5;
        logic        [63:0] p6_to_p9;
    } t_cal;

    typedef enum logic [2:0] {
        CFG_T1  = 3'd0,
        CFG_T2  = 3'd1,
        CFG_T3  = 3'd2,
        CFG_P1  = 3'd3,
        CFG_P25 = 3'd4,
        CFG_P69 = 3'd5
    } t_cfg_idx;

    localparam logic [63:0] C_T_OFS     = 64'd128000;
    localparam logic [20:0] C_P_OFS     = 21'd1048576;
    localparam logic [63:0] C_NUM_SCALE = 64'd3125;
    localparam logic [63:0] C_DEN_OFS   = 64'h0000_8000_0000_0000;
    localparam int          C_DIV_STEPS = 64;

    // Sign-extended 16-bit word k out of a packed group of four.
    function automatic logic [63:0] pword(input logic [63:0] w, input int k);
        logic [15:0] s;
        s = w[16*k +: 16];
        return {{48{s[15]}}, s};
    endfunction

endpackage

// ===== rtl/bsc_mmul.sv =====
// Two-stage 64 by 64 multiplier that keeps the low 64 bits of the product.
module bsc_mmul (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;
    logic [63:0] w_ll;
    logic [31:0] w_lh;
    logic [31:0] w_hl;

    // Only the cross terms' low halves reach the low 64 bits of the product.
    assign w_ll = {32'd0, i_a[31:0]} * {32'd0, i_b[31:0]};
    assign w_lh = i_a[31:0] * i_b[63:32];
    assign w_hl = i_a[63:32] * i_b[31:0];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ll <= w_ll;
            r_lh <= w_lh;
            r_hl <= w_hl;
            r_p  <= r_ll + {r_lh + r_hl, 32'd0};
        end
    end

    assign o_p = r_p;
endmodule

// ===== rtl/bsc_front.sv =====
// Temperature compensation and the pressure numerator and denominator.
module bsc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  logic [19:0]   i_raw_pressure,
    input  logic [19:0]   i_raw_temperature,
    input  bsc_pkg::t_cal i_cal,
    output logic          o_vld,
    output logic [63:0]   o_num,
    output logic [63:0]   o_den,
    output logic [31:0]   o_tc,
    output logic [31:0]   o_tf
);
    import bsc_pkg::*;

    logic [12:1] r_vld;
    logic [19:0] r_rp [1:9];
    logic [31:0] r_tf [3:12];
    logic [31:0] r_tc [4:12];
    logic [63:0] r_w1 [4:6];
    logic [31:0] r1_v1raw;
    logic [31:0] r1_bb;
    logic [31:0] r2_v1;
    logic [31:0] r2_x3;
    logic [63:0] r9_w2;
    logic [63:0] r9_w1n;
    logic [63:0] r10_num0;
    logic [63:0] r10_den0;

    logic signed [17:0] w_a;
    logic signed [17:0] w_b;
    logic signed [33:0] w_at2;
    logic signed [35:0] w_bb;
    logic signed [31:0] w_x;
    logic signed [47:0] w_x3;
    logic        [31:0] w_x3s;
    logic        [31:0] w_tf5;
    logic        [31:0] w_tc;
    logic        [63:0] w_sq;
    logic        [63:0] w_a6;
    logic        [63:0] w_c3;
    logic        [63:0] w_b5;
    logic        [63:0] w_d2;
    logic        [63:0] w_c3s;
    logic        [20:0] w_p21;
    logic        [63:0] w_num;
    logic        [63:0] w_den;

    assign w_a   = $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, i_cal.t1, 1'b0});
    assign w_b   = $signed({2'b0, i_raw_temperature[19:4]}) - $signed({2'b0, i_cal.t1});
    assign w_at2 = w_a * $signed(i_cal.t2);
    assign w_bb  = w_b * w_b;
    assign w_x   = $signed(r1_bb) >>> 12;
    assign w_x3  = w_x * $signed(i_cal.t3);
    assign w_x3s = $signed(r2_x3) >>> 14;
    assign w_tf5 = (r_tf[3] << 2) + r_tf[3];
    assign w_tc  = $signed(w_tf5 + 32'd128) >>> 8;
    assign w_c3s = $signed(w_c3) >>> 8;
    assign w_p21 = C_P_OFS - {1'b0, r_rp[9]};

    bsc_mmul u_sq (.i_clk(i_clk), .i_ce(i_ce), .i_a(r_w1[4]), .i_b(r_w1[4]), .o_p(w_sq));
    bsc_mmul u_p6 (.i_clk(i_clk), .i_ce(i_ce), .i_a(w_sq), .i_b(pword(i_cal.p6_to_p9, 0)),
                   .o_p(w_a6));
    bsc_mmul u_p3 (.i_clk(i_clk), .i_ce(i_ce), .i_a(w_sq), .i_b(pword(i_cal.p2_to_p5, 1)),
                   .o_p(w_c3));
    bsc_mmul u_p5 (.i_clk(i_clk), .i_ce(i_ce), .i_a(r_w1[6]), .i_b(pword(i_cal.p2_to_p5, 3)),
                   .o_p(w_b5));
    bsc_mmul u_p2 (.i_clk(i_clk), .i_ce(i_ce), .i_a(r_w1[6]), .i_b(pword(i_cal.p2_to_p5, 0)),
                   .o_p(w_d2));
    bsc_mmul u_num (.i_clk(i_clk), .i_ce(i_ce), .i_a(r10_num0), .i_b(C_NUM_SCALE),
                    .o_p(w_num));
    bsc_mmul u_den (.i_clk(i_clk), .i_ce(i_ce), .i_a(r10_den0), .i_b({48'd0, i_cal.p1}),
                    .o_p(w_den));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[11:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rp[1] <= i_raw_pressure;
            for (int k = 2; k <= 9; k++) r_rp[k] <= r_rp[k-1];
            r1_v1raw <= w_at2[31:0];
            r1_bb    <= w_bb[31:0];
            r2_v1    <= $signed(r1_v1raw) >>> 11;
            r2_x3    <= w_x3[31:0];
            r_tf[3]  <= r2_v1 + w_x3s;
            for (int k = 4; k <= 12; k++) r_tf[k] <= r_tf[k-1];
            r_tc[4]  <= w_tc;
            for (int k = 5; k <= 12; k++) r_tc[k] <= r_tc[k-1];
            r_w1[4]  <= {{32{r_tf[3][31]}}, r_tf[3]} - C_T_OFS;
            r_w1[5]  <= r_w1[4];
            r_w1[6]  <= r_w1[5];
            r9_w2    <= w_a6 + (w_b5 << 17) + (pword(i_cal.p2_to_p5, 2) << 35);
            r9_w1n   <= w_c3s + (w_d2 << 12);
            r10_num0 <= ({43'd0, w_p21} << 31) - r9_w2;
            r10_den0 <= C_DEN_OFS + r9_w1n;
        end
    end

    assign o_vld = r_vld[12];
    assign o_num = w_num;
    assign o_den = $signed(w_den) >>> 33;
    assign o_tc  = r_tc[12];
    assign o_tf  = r_tf[12];
endmodule

// ===== rtl/bsc_sdiv.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
module bsc_sdiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  logic        i_vld,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    input  logic [31:0] i_tc,
    input  logic [31:0] i_tf,
    output logic        o_vld,
    output logic [63:0] o_quo,
    output logic        o_zero,
    output logic [31:0] o_tc,
    output logic [31:0] o_tf
);
    import bsc_pkg::*;

    logic [C_DIV_STEPS+1:0] r_vld;
    logic [63:0] r_rem [0:C_DIV_STEPS];
    logic [63:0] r_quo [0:C_DIV_STEPS];
    logic [63:0] r_dvs [0:C_DIV_STEPS];
    logic        r_neg [0:C_DIV_STEPS];
    logic        r_zero [0:C_DIV_STEPS+1];
    logic [31:0] r_tc [0:C_DIV_STEPS+1];
    logic [31:0] r_tf [0:C_DIV_STEPS+1];
    logic [63:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[C_DIV_STEPS:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= '0;
            r_quo[0]  <= i_num[63] ? 64'd0 - i_num : i_num;
            r_dvs[0]  <= i_den[63] ? 64'd0 - i_den : i_den;
            r_neg[0]  <= i_num[63] ^ i_den[63];
            r_zero[0] <= (i_den == 64'd0);
            r_tc[0]   <= i_tc;
            r_tf[0]   <= i_tf;
            for (int k = 1; k <= C_DIV_STEPS; k++) begin
                r_dvs[k] <= r_dvs[k-1];
                r_neg[k] <= r_neg[k-1];
            end
            for (int k = 1; k <= C_DIV_STEPS + 1; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_tc[k]   <= r_tc[k-1];
                r_tf[k]   <= r_tf[k-1];
            end
            r_out <= r_neg[C_DIV_STEPS] ? 64'd0 - r_quo[C_DIV_STEPS] : r_quo[C_DIV_STEPS];
        end
    end

    // The dividend shifts out of the quotient register while quotient bits shift in.
    for (genvar k = 1; k <= C_DIV_STEPS; k++) begin : g_step
        logic [64:0] w_sh;
        logic [64:0] w_dif;
        assign w_sh  = {r_rem[k-1], r_quo[k-1][63]};
        assign w_dif = w_sh - {1'b0, r_dvs[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= w_dif[64] ? w_sh[63:0] : w_dif[63:0];
                r_quo[k] <= {r_quo[k-1][62:0], ~w_dif[64]};
            end
        end
    end

    assign o_vld  = r_vld[C_DIV_STEPS+1];
    assign o_quo  = r_out;
    assign o_zero = r_zero[C_DIV_STEPS+1];
    assign o_tc   = r_tc[C_DIV_STEPS+1];
    assign o_tf   = r_tf[C_DIV_STEPS+1];
endmodule

// ===== rtl/bsc_back.sv =====
// Pressure correction after the division and the output register.
module bsc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  logic [63:0]   i_quo,
    input  logic          i_zero,
    input  logic [31:0]   i_tc,
    input  logic [31:0]   i_tf,
    input  bsc_pkg::t_cal i_cal,
    output logic          o_vld,
    output logic [31:0]   o_temperature_centi,
    output logic [31:0]   o_fine_temperature,
    output logic [31:0]   o_pressure,
    output logic          o_zero_divisor
);
    import bsc_pkg::*;

    logic [7:1]  r_vld;
    logic [63:0] r_p [1:4];
    logic [63:0] r_w8 [3:4];
    logic        r_zero [1:7];
    logic [31:0] r_tc [1:7];
    logic [31:0] r_tf [1:7];
    logic [63:0] r_s;
    logic [63:0] r_r;
    logic [31:0] r_pa;

    logic [63:0] w_h0;
    logic [63:0] w_h2;
    logic [63:0] w_ph;
    logic [63:0] w_p8;
    logic [63:0] w_phh;
    logic [63:0] w_p8s;
    logic [63:0] w_phhs;
    logic [63:0] w_ss;
    logic [63:0] w_rnd;
    logic [63:0] w_pa64;

    assign w_h0   = $signed(i_quo) >>> 13;
    assign w_h2   = $signed(r_p[2]) >>> 13;
    assign w_p8s  = $signed(w_p8) >>> 19;
    assign w_phhs = $signed(w_phh) >>> 25;
    assign w_ss   = $signed(r_s) >>> 8;
    // A shift by 8 floors, so negatives are biased to truncate toward zero.
    assign w_rnd  = r_r + (r_r[63] ? 64'd255 : 64'd0);
    assign w_pa64 = $signed(w_rnd) >>> 8;

    bsc_mmul u_ph  (.i_clk(i_clk), .i_ce(i_ce), .i_a(pword(i_cal.p6_to_p9, 3)), .i_b(w_h0),
                    .o_p(w_ph));
    bsc_mmul u_p8  (.i_clk(i_clk), .i_ce(i_ce), .i_a(pword(i_cal.p6_to_p9, 2)), .i_b(i_quo),
                    .o_p(w_p8));
    bsc_mmul u_phh (.i_clk(i_clk), .i_ce(i_ce), .i_a(w_ph), .i_b(w_h2), .o_p(w_phh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[6:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p[1] <= i_quo;
            for (int k = 2; k <= 4; k++) r_p[k] <= r_p[k-1];
            r_w8[3] <= w_p8s;
            r_w8[4] <= r_w8[3];
            r_zero[1] <= i_zero;
            r_tc[1]   <= i_tc;
            r_tf[1]   <= i_tf;
            for (int k = 2; k <= 7; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_tc[k]   <= r_tc[k-1];
                r_tf[k]   <= r_tf[k-1];
            end
            r_s  <= r_p[4] + w_phhs + r_w8[4];
            r_r  <= w_ss + (pword(i_cal.p6_to_p9, 1) << 4);
            r_pa <= r_zero[6] ? 32'd0 : w_pa64[31:0];
        end
    end

    assign o_vld               = r_vld[7];
    assign o_temperature_centi = r_tc[7];
    assign o_fine_temperature  = r_tf[7];
    assign o_pressure          = r_pa;
    assign o_zero_divisor      = r_zero[7];
endmodule

// ===== rtl/barometric_sensor_compensation.sv =====
// Top level of the barometric compensation pipeline with its calibration registers.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------------
//   input    | i_valid / o_stall    | i_raw_pressure, i_raw_temperature
//   output   | o_valid / i_stall    | o_temperature_centi, o_fine_temperature,
//            |                      | o_pressure, o_zero_divisor
//   config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One transaction is accepted every cycle while the output is not stalled.
// The 64-stage divider, one quotient bit per stage, makes up most of the pipeline.
// Reset clears the calibration registers and every valid bit; payload is not reset.
// A stalled output freezes the whole pipeline, so nothing is dropped or repeated.
module barometric_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_raw_pressure,
    input  logic [19:0] i_raw_temperature,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_temperature_centi,
    output logic [31:0] o_fine_temperature,
    output logic [31:0] o_pressure,
    output logic        o_zero_divisor,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import bsc_pkg::*;

    t_cal        r_cal;
    logic        w_ce;
    logic        w_f_vld;
    logic [63:0] w_num;
    logic [63:0] w_den;
    logic [31:0] w_f_tc;
    logic [31:0] w_f_tf;
    logic        w_d_vld;
    logic [63:0] w_quo;
    logic        w_d_zero;
    logic [31:0] w_d_tc;
    logic [31:0] w_d_tf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_T1:  r_cal.t1       <= i_cfg_data[15:0];
                CFG_T2:  r_cal.t2       <= i_cfg_data[15:0];
                CFG_T3:  r_cal.t3       <= i_cfg_data[15:0];
                CFG_P1:  r_cal.p1       <= i_cfg_data[15:0];
                CFG_P25: r_cal.p2_to_p5 <= i_cfg_data;
                CFG_P69: r_cal.p6_to_p9 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = o_valid & i_stall;
    assign w_ce    = ~o_stall;

    bsc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ce              (w_ce),
        .i_vld             (i_valid),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_cal             (r_cal),
        .o_vld             (w_f_vld),
        .o_num             (w_num),
        .o_den             (w_den),
        .o_tc              (w_f_tc),
        .o_tf              (w_f_tf)
    );

    bsc_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_vld   (w_f_vld),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_tc    (w_f_tc),
        .i_tf    (w_f_tf),
        .o_vld   (w_d_vld),
        .o_quo   (w_quo),
        .o_zero  (w_d_zero),
        .o_tc    (w_d_tc),
        .o_tf    (w_d_tf)
    );

    bsc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ce                (w_ce),
        .i_vld               (w_d_vld),
        .i_quo               (w_quo),
        .i_zero              (w_d_zero),
        .i_tc                (w_d_tc),
        .i_tf                (w_d_tf),
        .i_cal               (r_cal),
        .o_vld               (o_valid),
        .o_temperature_centi (o_temperature_centi),
        .o_fine_temperature  (o_fine_temperature),
        .o_pressure          (o_pressure),
        .o_zero_divisor      (o_zero_divisor)
    );

    a_zero_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_divisor |-> o_pressure == 32'd0)
        else $error("zero divisor flagged with nonzero pressure");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while no result is waiting");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_frozen_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(w_f_vld) && $stable(w_num))
        else $error("pipeline moved during an output stall");
endmodule
